// ----- rtl/slab_cache_bitmap_allocator_top_assert.svh -----
// Assertion macros for the slab cache bitmap allocator.
`ifndef SLAB_CACHE_BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`define SLAB_CACHE_BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTH
`define SCBA_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("slab allocator check failed");
`define SCBA_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("slab allocator implication failed");
`else
`define SCBA_ASSERT(label, prop)
`define SCBA_ASSERT_IMP(label, ante, cons)
`endif
`endif

// ----- rtl/scba_pkg.sv -----
package scba_pkg;

   localparam int ADDR_W     = 32;
   localparam int OBJ_SIZE_W = 13;
   localparam int STATUS_W   = 3;
   localparam int SLOT_IDX_W = 5;

   localparam logic [OBJ_SIZE_W-1:0] OBJ_SIZE_RESET = 13'd64;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STS_ALLOC_OLD = 3'd0;
   localparam logic [STATUS_W-1:0] STS_ALLOC_NEW = 3'd1;
   localparam logic [STATUS_W-1:0] STS_NO_MEM    = 3'd2;
   localparam logic [STATUS_W-1:0] STS_FREED     = 3'd3;
   localparam logic [STATUS_W-1:0] STS_IGNORED   = 3'd4;

   typedef struct packed {
      logic              op;
      logic [ADDR_W-1:0] address;
      logic [ADDR_W-1:0] new_page;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   result_address;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // Search token handed from cell to cell.
   typedef struct packed {
      logic                  valid;
      logic                  found;
      logic [SLOT_IDX_W-1:0] slot;
      logic [ADDR_W-1:0]     base;
   } token_type;

   // Broadcast update from the controller to the cells.
   typedef struct packed {
      logic                  adopt;
      logic                  clear;
      logic [SLOT_IDX_W-1:0] slot;
      logic [ADDR_W-1:0]     base;
   } cmd_type;

endpackage

// ----- rtl/scba_cell.sv -----
module scba_cell #(
   parameter int INDEX      = 0,
   parameter int CNT_W      = 7,
   parameter int SLOT_W     = 32,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  scba_pkg::token_type         prev_tok,
   output scba_pkg::token_type         next_tok,
   input  scba_pkg::cmd_type           cmd,
   input  logic                        op,
   input  logic [scba_pkg::ADDR_W-1:0] address,
   input  logic [SLOT_W-1:0]           slot_mask,
   input  logic [CNT_W-1:0]            page_count
);
   import scba_pkg::*;

   logic [ADDR_W-1:0]     base_ff, base_in;
   logic [SLOT_W-1:0]     bitmap_ff, bitmap_in;
   token_type             tok_ff, tok_in;
   logic                  hit_ff, hit_in;
   logic                  used;
   logic                  has_free;
   logic                  in_window;
   logic [SLOT_W-1:0]     free_bits;
   logic [SLOT_W-1:0]     set_mask;
   logic [SLOT_IDX_W-1:0] slot_enc;
   logic [ADDR_W:0]       diff;

   always_comb begin
      used      = page_count > CNT_W'(INDEX);
      free_bits = ~bitmap_ff & slot_mask;
      has_free  = |free_bits;
      // Isolate the lowest free slot.
      set_mask  = free_bits & (~free_bits + SLOT_W'(1));
      slot_enc  = '0;
      for (int i = SLOT_W - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            slot_enc = SLOT_IDX_W'(i);
         end
      end
      diff      = {1'b0, address} - {1'b0, base_ff};
      in_window = !diff[ADDR_W] && (diff[ADDR_W-1:0] < ADDR_W'(PAGE_BYTES));

      tok_in    = prev_tok;
      hit_in    = hit_ff;
      base_in   = base_ff;
      bitmap_in = bitmap_ff;
      if (prev_tok.valid) begin
         hit_in = 1'b0;
         if (!prev_tok.found && used) begin
            if (op == OP_ALLOC) begin
               if (has_free) begin
                  tok_in.found = 1'b1;
                  tok_in.slot  = slot_enc;
                  tok_in.base  = base_ff;
                  bitmap_in    = bitmap_ff | set_mask;
               end
            end else if (in_window) begin
               tok_in.found = 1'b1;
               tok_in.base  = base_ff;
               hit_in       = 1'b1;
            end
         end
      end
      if (cmd.adopt && page_count == CNT_W'(INDEX)) begin
         base_in   = cmd.base;
         bitmap_in = SLOT_W'(1);
      end
      // The cell that matched the last free is the one that clears its bit.
      if (cmd.clear && hit_ff) begin
         bitmap_in = bitmap_ff & ~(SLOT_W'(1) << cmd.slot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff   <= base_in;
      bitmap_ff <= bitmap_in;
   end

   assign next_tok = tok_ff;

endmodule

// ----- rtl/scba_div.sv -----
module scba_div #(
   parameter int DIVIDEND_W = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [DIVIDEND_W-1:0]           dividend,
   input  logic [scba_pkg::OBJ_SIZE_W-1:0] divisor,
   output logic                            done,
   output logic [DIVIDEND_W-1:0]           quotient
);
   import scba_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [OBJ_SIZE_W-1:0] rem_ff, rem_in;
   logic [OBJ_SIZE_W-1:0] dsr_ff, dsr_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [OBJ_SIZE_W:0]   trial;
   logic [OBJ_SIZE_W:0]   diff;
   logic                  ge;

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      ge      = trial >= {1'b0, dsr_ff};
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = CNT_W'(DIVIDEND_W);
         rem_in = '0;
         dsr_in = divisor;
         quo_in = dividend;
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? diff[OBJ_SIZE_W-1:0] : trial[OBJ_SIZE_W-1:0];
         quo_in  = {quo_ff[DIVIDEND_W-2:0], ge};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = cnt_ff == CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/slab_cache_bitmap_allocator_top.sv -----
// Each accepted item makes one pass down the chain of page cells; an allocate in a held page then
// computes its address in S_MUL and S_SUM, a free finds its slot with the bit-serial divider,
// and an adopt, a failed allocate or an ignored free goes straight to S_DONE;
// an object size of zero skips the chain. One item is in work at a time.
// Reset (synchronous, active high) empties the page table and sets the object size to 64;
// the slot mask is rebuilt then and after each write, and no request is taken until it is done.
`include "slab_cache_bitmap_allocator_top_assert.svh"

module slab_cache_bitmap_allocator_top #(
   parameter int MAX_PAGES      = 64,
   parameter int SLOTS_PER_PAGE = 32,
   parameter int PAGE_BYTES     = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  scba_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output scba_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [scba_pkg::OBJ_SIZE_W-1:0] csr_data
);
   import scba_pkg::*;

   localparam int SLOT_W = (SLOTS_PER_PAGE > 32) ? 32 : SLOTS_PER_PAGE;
   localparam int CNT_W  = $clog2(MAX_PAGES + 1);
   localparam int OFF_W  = $clog2(PAGE_BYTES);
   localparam int MK_W   = $clog2(SLOT_W + 1);
   localparam int ACC_W  = OBJ_SIZE_W + MK_W;
   localparam int PROD_W = SLOT_IDX_W + OBJ_SIZE_W;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_PASS = 6'b000010,
      S_MUL  = 6'b000100,
      S_SUM  = 6'b001000,
      S_DIV  = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [OBJ_SIZE_W-1:0] obj_size_ff, obj_size_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [MK_W-1:0]       mk_cnt_ff, mk_cnt_in;
   logic [SLOT_W-1:0]     mask_ff, mask_in;
   logic [CNT_W-1:0]      page_count_ff, page_count_in;
   req_type               req_ff, req_in;
   logic                  launch_ff, launch_in;
   logic [SLOT_IDX_W-1:0] slot_ff, slot_in;
   logic [ADDR_W-1:0]     base_ff, base_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   rsp_type               res_ff, res_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   token_type             tok [MAX_PAGES+1];
   logic [MAX_PAGES:0]    tok_valid;
   token_type             chain_out;
   cmd_type               cmd;
   logic                  fits;
   logic                  can_adopt;
   logic                  div_start;
   logic                  div_done;
   logic [OFF_W-1:0]      div_quo;
   logic [OFF_W-1:0]      offset;

   assign tok[0]    = '{valid: launch_ff, found: 1'b0, slot: '0, base: '0};
   assign chain_out = tok[MAX_PAGES];

   for (genvar g = 0; g <= MAX_PAGES; g++) begin : g_tok_valid
      assign tok_valid[g] = tok[g].valid;
   end

   for (genvar g = 0; g < MAX_PAGES; g++) begin : g_cell
      scba_cell #(
         .INDEX      (g),
         .CNT_W      (CNT_W),
         .SLOT_W     (SLOT_W),
         .PAGE_BYTES (PAGE_BYTES)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .prev_tok   (tok[g]),
         .next_tok   (tok[g+1]),
         .cmd        (cmd),
         .op         (req_ff.op),
         .address    (req_ff.address),
         .slot_mask  (mask_ff),
         .page_count (page_count_ff)
      );
   end

   assign offset = OFF_W'(req_ff.address - chain_out.base);

   scba_div #(
      .DIVIDEND_W (OFF_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (offset),
      .divisor  (obj_size_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_ready = (state_ff == S_IDLE) && (mk_cnt_ff == '0);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      // Slot s is usable when (s + 1) objects still fit in one page.
      fits      = 32'(acc_ff) <= 32'(PAGE_BYTES);
      can_adopt = (page_count_ff < CNT_W'(MAX_PAGES)) && (req_ff.new_page != '0);

      state_in      = state_ff;
      obj_size_in   = obj_size_ff;
      acc_in        = acc_ff;
      mk_cnt_in     = mk_cnt_ff;
      mask_in       = mask_ff;
      page_count_in = page_count_ff;
      req_in        = req_ff;
      launch_in     = 1'b0;
      slot_in       = slot_ff;
      base_in       = base_ff;
      prod_in       = prod_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      div_start     = 1'b0;
      cmd           = '0;

      if (csr_valid) begin
         obj_size_in = csr_data;
         acc_in      = ACC_W'(csr_data);
         mk_cnt_in   = MK_W'(SLOT_W);
      end else if (mk_cnt_ff != '0) begin
         mask_in   = (mask_ff >> 1) | (SLOT_W'(fits) << (SLOT_W - 1));
         acc_in    = acc_ff + ACC_W'(obj_size_ff);
         mk_cnt_in = mk_cnt_ff - MK_W'(1);
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               req_in = req_data;
               if (obj_size_ff == '0) begin
                  res_in.result_address = '0;
                  res_in.status = (req_data.op == OP_FREE) ? STS_IGNORED : STS_NO_MEM;
                  state_in = S_DONE;
               end else begin
                  launch_in = 1'b1;
                  state_in  = S_PASS;
               end
            end
         end
         S_PASS: begin
            if (chain_out.valid) begin
               res_in.result_address = '0;
               if (req_ff.op == OP_ALLOC) begin
                  if (chain_out.found) begin
                     slot_in  = chain_out.slot;
                     base_in  = chain_out.base;
                     state_in = S_MUL;
                  end else if (can_adopt) begin
                     cmd.adopt             = 1'b1;
                     cmd.base              = req_ff.new_page;
                     page_count_in         = page_count_ff + CNT_W'(1);
                     res_in.result_address = req_ff.new_page;
                     res_in.status         = STS_ALLOC_NEW;
                     state_in              = S_DONE;
                  end else begin
                     res_in.status = STS_NO_MEM;
                     state_in      = S_DONE;
                  end
               end else if (chain_out.found) begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end else begin
                  res_in.status = STS_IGNORED;
                  state_in      = S_DONE;
               end
            end
         end
         S_MUL: begin
            prod_in  = PROD_W'(slot_ff) * PROD_W'(obj_size_ff);
            state_in = S_SUM;
         end
         S_SUM: begin
            res_in.result_address = base_ff + ADDR_W'(prod_ff);
            res_in.status         = STS_ALLOC_OLD;
            state_in              = S_DONE;
         end
         S_DIV: begin
            if (div_done) begin
               // A slot past the bitmap leaves every bit as it is.
               cmd.clear             = div_quo < OFF_W'(SLOT_W);
               cmd.slot              = div_quo[SLOT_IDX_W-1:0];
               res_in.result_address = '0;
               res_in.status         = STS_FREED;
               state_in              = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         obj_size_ff   <= OBJ_SIZE_RESET;
         acc_ff        <= ACC_W'(OBJ_SIZE_RESET);
         mk_cnt_ff     <= MK_W'(SLOT_W);
         page_count_ff <= '0;
         launch_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         obj_size_ff   <= obj_size_in;
         acc_ff        <= acc_in;
         mk_cnt_ff     <= mk_cnt_in;
         page_count_ff <= page_count_in;
         launch_ff     <= launch_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      req_ff  <= req_in;
      slot_ff <= slot_in;
      base_ff <= base_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   `SCBA_ASSERT(a_single_token, $onehot0(tok_valid))
   `SCBA_ASSERT_IMP(a_token_only_in_pass, |tok_valid, state_ff == S_PASS)
   `SCBA_ASSERT_IMP(a_count_on_adopt, page_count_ff != $past(page_count_ff), $past(cmd.adopt))

endmodule

// ----- tb/slab_cache_bitmap_allocator_top_tb.sv -----
module slab_cache_bitmap_allocator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import scba_pkg::*;

   localparam int TABLE_DEPTH  = 64;
   localparam int SLOT_CAP     = 32;
   localparam int PAGE_SPAN    = 4096;
   localparam int IDLE_PCT     = 11;
   localparam int DRAIN_CYCLES = 120;
   localparam int CYCLE_LIMIT  = 1500000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [OBJ_SIZE_W-1:0] csr_data;

   // Shadow copy of the allocator state.
   logic [ADDR_W-1:0]     page_tbl [TABLE_DEPTH];
   logic [31:0]           used_map [TABLE_DEPTH];
   int unsigned           pages_held;
   logic [OBJ_SIZE_W-1:0] obj_bytes;

   rsp_type           awaited_answers[$];
   logic [ADDR_W-1:0] live_objs[$];

   bit steady;
   int fail_count;
   int items_sent;
   int answers_seen;
   int size_writes;
   int cycle_count;
   int tally_old;
   int tally_new;
   int tally_nomem;
   int tally_freed;
   int tally_ignored;

   slab_cache_bitmap_allocator_top #(
      .MAX_PAGES      (TABLE_DEPTH),
      .SLOTS_PER_PAGE (SLOT_CAP),
      .PAGE_BYTES     (PAGE_SPAN)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned slots_in_page();
      int unsigned n;
      n = PAGE_SPAN / obj_bytes;
      if (n > SLOT_CAP) begin
         n = SLOT_CAP;
      end
      return n;
   endfunction

   // Works out the answer to one item and updates the shadow state.
   function automatic rsp_type slab_answer(req_type item);
      rsp_type           ans;
      int unsigned       n;
      int unsigned       p;
      int unsigned       s;
      int unsigned       slot;
      logic [ADDR_W:0]   upper;
      logic [ADDR_W-1:0] offset;
      ans.result_address = '0;
      ans.status = STS_NO_MEM;
      if (item.op == OP_ALLOC) begin
         if (obj_bytes == 0) begin
            return ans;
         end
         n = slots_in_page();
         for (p = 0; p < pages_held; p++) begin
            for (s = 0; s < n; s++) begin
               if (!used_map[p][s]) begin
                  used_map[p][s] = 1'b1;
                  ans.result_address = page_tbl[p] + ADDR_W'(s) * ADDR_W'(obj_bytes);
                  ans.status = STS_ALLOC_OLD;
                  return ans;
               end
            end
         end
         if (pages_held >= TABLE_DEPTH || item.new_page == 0) begin
            return ans;
         end
         page_tbl[pages_held] = item.new_page;
         used_map[pages_held] = 32'd1;
         pages_held++;
         ans.result_address = item.new_page;
         ans.status = STS_ALLOC_NEW;
         return ans;
      end
      ans.status = STS_IGNORED;
      if (obj_bytes == 0 || item.address == 0) begin
         return ans;
      end
      // The window test is done one bit wider so that it never wraps.
      for (p = 0; p < pages_held; p++) begin
         upper = {1'b0, page_tbl[p]} + (ADDR_W + 1)'(PAGE_SPAN);
         if (item.address >= page_tbl[p] && {1'b0, item.address} < upper) begin
            offset = item.address - page_tbl[p];
            slot = offset / obj_bytes;
            if (slot < 32) begin
               used_map[p][slot] = 1'b0;
            end
            ans.status = STS_FREED;
            return ans;
         end
      end
      return ans;
   endfunction

   function automatic req_type alloc_item(logic [ADDR_W-1:0] offer);
      req_type item;
      item.op = OP_ALLOC;
      item.address = $urandom;
      item.new_page = offer;
      return item;
   endfunction

   function automatic req_type free_item(logic [ADDR_W-1:0] addr);
      req_type item;
      item.op = OP_FREE;
      item.address = addr;
      item.new_page = $urandom;
      return item;
   endfunction

   function automatic logic [ADDR_W-1:0] pick_offer();
      logic [ADDR_W-1:0] offer;
      logic [ADDR_W-1:0] held;
      held = (pages_held != 0) ? page_tbl[$urandom_range(pages_held - 1)] : $urandom;
      case ($urandom_range(9))
         0: begin
            offer = '0;
         end
         1: begin
            offer = 32'hFFFF_F000 | $urandom_range(PAGE_SPAN - 1);
         end
         2: begin
            offer = held;
         end
         3: begin
            offer = held + $urandom_range(PAGE_SPAN - 1, 1);
         end
         default: begin
            offer = $urandom;
         end
      endcase
      return offer;
   endfunction

   // Mostly frees an object handed out earlier; the rest is noise near and
   // away from the held pages.
   function automatic logic [ADDR_W-1:0] pick_free_address();
      int unsigned       roll;
      int unsigned       idx;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] held;
      roll = $urandom_range(99);
      held = (pages_held != 0) ? page_tbl[$urandom_range(pages_held - 1)] : $urandom;
      if (roll < 70 && live_objs.size() != 0) begin
         idx = $urandom_range(live_objs.size() - 1);
         addr = live_objs[idx];
         live_objs.delete(idx);
      end else if (roll < 82) begin
         addr = held + $urandom_range(PAGE_SPAN - 1);
      end else if (roll < 88) begin
         addr = ($urandom_range(1) != 0) ? held - 1 : held + PAGE_SPAN;
      end else if (roll < 92) begin
         addr = '0;
      end else begin
         addr = $urandom;
      end
      return addr;
   endfunction

   function automatic req_type random_item(int alloc_pct);
      if ($urandom_range(99) < alloc_pct) begin
         return alloc_item(pick_offer());
      end
      return free_item(pick_free_address());
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   // with valid still high, so that a following item can go out without a gap.
   task automatic send_item(req_type item);
      rsp_type ans;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      ans = slab_answer(item);
      awaited_answers.push_back(ans);
      items_sent++;
      case (ans.status)
         STS_ALLOC_OLD: begin
            tally_old++;
            live_objs.push_back(ans.result_address);
         end
         STS_ALLOC_NEW: begin
            tally_new++;
            live_objs.push_back(ans.result_address);
         end
         STS_NO_MEM: begin
            tally_nomem++;
         end
         STS_FREED: begin
            tally_freed++;
         end
         default: begin
            tally_ignored++;
         end
      endcase
      @(negedge clock);
   endtask

   // The object size is only changed once every answer has come back.
   task automatic write_size(logic [OBJ_SIZE_W-1:0] value);
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_answers.size() != 0);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      obj_bytes = value;
      size_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(int count, int alloc_pct);
      repeat (count) begin
         send_item(random_item(alloc_pct));
      end
   endtask

   task automatic test_directed();
      // Empty table at the reset size, then a page at the top of the address space.
      send_item(free_item('0));
      send_item(free_item(32'hFFFF_FFFF));
      send_item(alloc_item('0));
      send_item(alloc_item(32'hFFFF_F800));
      send_item(alloc_item(32'h1234_5000));
      send_item(free_item(32'hFFFF_F840));
      send_item(free_item(32'hFFFF_FA00));
      send_item(free_item(32'hFFFF_F7FF));
      // With 2048-byte objects the second slot of that page wraps to zero.
      write_size(13'd2048);
      send_item(alloc_item('0));
      send_item(alloc_item(32'hFFFF_F800));
      send_item(alloc_item('0));
      send_item(free_item(32'hFFFF_F900));
      send_item(alloc_item('0));
      write_size('0);
      send_item(alloc_item(32'h0000_0100));
      send_item(free_item(32'hFFFF_F800));
      // An object larger than a page never fits, so an allocate can only succeed by adopting.
      write_size('1);
      send_item(alloc_item(32'h0000_0001));
      send_item(free_item(32'h0000_1000));
      send_item(free_item(32'h0000_1001));
      write_size(13'd1);
      send_item(alloc_item('0));
      send_item(free_item(32'hFFFF_F81F));
      send_item(free_item(32'hFFFF_F820));
      write_size(13'd4096);
      send_item(alloc_item('0));
      send_item(alloc_item('0));
      send_item(alloc_item(32'h8000_0000));
   endtask

   task automatic test_random_small();
      int round;
      for (round = 0; round < 4; round++) begin
         write_size((round == 0) ? OBJ_SIZE_W'(1) : OBJ_SIZE_W'($urandom_range(128, 2)));
         steady = (round == 1);
         run_random(200, 60);
      end
      steady = 1'b0;
   endtask

   task automatic test_random_wide();
      int round;
      for (round = 0; round < 4; round++) begin
         case (round)
            0: begin
               write_size(OBJ_SIZE_W'($urandom_range(4096, 129)));
            end
            1: begin
               write_size(13'd4096);
            end
            2: begin
               write_size(OBJ_SIZE_W'($urandom_range(8191, 4097)));
            end
            default: begin
               write_size(OBJ_SIZE_W'($urandom_range(4095, 129)));
            end
         endcase
         run_random(150, 55);
      end
   endtask

   task automatic test_table_full();
      int guard;
      write_size(13'd4096);
      guard = 0;
      while (pages_held < TABLE_DEPTH && guard < 4 * TABLE_DEPTH) begin
         send_item(alloc_item($urandom | 32'h1));
         guard++;
      end
      repeat (3) begin
         send_item(alloc_item($urandom | 32'h1));
      end
      if (live_objs.size() != 0) begin
         send_item(free_item(live_objs.pop_back()));
      end
      send_item(alloc_item($urandom | 32'h1));
      send_item(alloc_item('0));
   endtask

   task automatic test_random_full_table();
      write_size(13'd1);
      run_random(150, 50);
      write_size(OBJ_SIZE_W'($urandom_range(64, 2)));
      run_random(150, 50);
      write_size('0);
      run_random(25, 50);
      write_size(OBJ_SIZE_W'($urandom_range(4096, 1)));
      run_random(150, 50);
   endtask

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         answers_seen++;
         if (awaited_answers.size() == 0) begin
            $error("unexpected result: result_address %h status %0d",
                   rsp_data.result_address, rsp_data.status);
            fail_count++;
         end else begin
            want = awaited_answers.pop_front();
            if (rsp_data.result_address !== want.result_address) begin
               $error("result_address: expected %h, got %h",
                      want.result_address, rsp_data.result_address);
               fail_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("slab_cache_bitmap_allocator_top verification failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      steady = 1'b0;
      obj_bytes = OBJ_SIZE_RESET;
      pages_held = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_small();
      test_random_wide();
      test_table_full();
      test_random_full_table();

      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_answers.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d items, checked %0d results over %0d object sizes; %0d pages held.",
               items_sent, answers_seen, size_writes, pages_held);
      $display("Outcomes: %0d old-page, %0d new-page, %0d out of memory, %0d freed, %0d ignored.",
               tally_old, tally_new, tally_nomem, tally_freed, tally_ignored);
      if (fail_count == 0) begin
         $display("slab_cache_bitmap_allocator_top verification clean");
      end else begin
         $display("slab_cache_bitmap_allocator_top verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/scba_pkg.sv
rtl/scba_cell.sv
rtl/scba_div.sv
rtl/slab_cache_bitmap_allocator_top.sv
tb/slab_cache_bitmap_allocator_top_tb.sv
